### rtl/arw_pkg.sv
// arw_pkg: shared types and constants for the anti-replay window checker
// no dependencies; imported by every module in rtl/

package arw_pkg;

  // fixed field widths of the request items
  localparam int CTR_W = 64;
  localparam int SID_W = 8;

  // default geometry, overridable at the top level
  localparam int DEF_WINDOW_BITS  = 64;
  localparam int DEF_NUM_SESSIONS = 256;

  // request kinds carried in in_tuser
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // verdict codes
  typedef enum logic [2:0] {
    VERDICT_NEW_HIGHEST = 3'd0,
    VERDICT_FRESH       = 3'd1,
    VERDICT_TOO_OLD     = 3'd2,
    VERDICT_REPLAY      = 3'd3,
    VERDICT_CLEARED     = 3'd4
  } verdict_t;

  // outcome of one window update
  typedef struct packed {
    logic     we;
    logic     accepted;
    verdict_t verdict;
  } upd_res_t;

  // control states of the top level
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ctrl_state_t;

endpackage

### rtl/anti_replay_window_check_unit.sv
// Anti-replay sliding-window checker. Each request on the in_ channel names a
// session and either clears its replay state or checks a packet counter; one
// result (accepted flag and verdict) leaves on the out_ channel per request.
// Requests are taken one per clock while results are taken; out_tvalid for a
// result rises once the result register has loaded it: the session state
// memory is read on the accepting edge, and the result register loads when the
// request stage fires. The pace is set by the registered read, with a bypass
// register for back-to-back requests to the same session. After reset the
// memory is swept to zero, one session per cycle; in_tready stays low meanwhile.
// Session indexes at or above NUM_SESSIONS wrap modulo NUM_SESSIONS.
// Depends on arw_pkg, arw_state_mem and arw_window_upd.

module anti_replay_window_check_unit
  import arw_pkg::*;
#(
  parameter int WINDOW_BITS  = DEF_WINDOW_BITS,
  parameter int NUM_SESSIONS = DEF_NUM_SESSIONS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // session_index[7:0], packet_counter[71:8]
  input  logic [0:0]  in_tuser,   // op[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // accepted[0], verdict[3:1], zero pad[7:4]
);

  localparam int IDX_W   = (NUM_SESSIONS > 1) ? $clog2(NUM_SESSIONS) : 1;
  localparam int ENT_W   = CTR_W + WINDOW_BITS;
  localparam int SID_CNT = 1 << SID_W;
  localparam int TBL_W   = SID_CNT * IDX_W;

  // session index to memory address, wrapped modulo the session count
  function automatic logic [TBL_W-1:0] build_idx_tbl();
    logic [TBL_W-1:0] tbl;
    int               r;
    tbl = '0;
    r   = 0;
    for (int i = 0; i < SID_CNT; i++) begin
      tbl[i*IDX_W +: IDX_W] = IDX_W'(r);
      r = r + 1;
      if (r == NUM_SESSIONS) begin
        r = 0;
      end
    end
    return tbl;
  endfunction

  localparam logic [TBL_W-1:0] IDX_TBL = build_idx_tbl();

  ctrl_state_t state_r, state_nxt;
  logic [IDX_W-1:0]       clr_idx_r;
  logic                   sweep;

  logic                   accept;
  logic [IDX_W-1:0]       in_idx;

  logic                   b_vld_r;
  logic                   b_op_r;
  logic [IDX_W-1:0]       b_idx_r;
  logic [CTR_W-1:0]       b_ctr_r;
  logic                   b_fwd_r;
  logic [ENT_W-1:0]       b_fwd_data_r;
  logic                   b_fire;

  logic [ENT_W-1:0]       mem_rdata;
  logic [ENT_W-1:0]       cur;
  logic [CTR_W-1:0]       new_hi;
  logic [WINDOW_BITS-1:0] new_map;
  logic [ENT_W-1:0]       new_ent;
  upd_res_t               upd;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic [ENT_W-1:0]       mem_wdata;

  logic                   out_vld_r;
  logic                   out_acc_r;
  verdict_t               out_verdict_r;

  // control state: sweep after reset, then run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (sweep) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_idx_r == IDX_W'(NUM_SESSIONS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // state outputs
  always_comb begin
    unique case (state_r)
      ST_CLEAR: sweep = 1'b1;
      ST_RUN:   sweep = 1'b0;
      default:  sweep = 1'b0;
    endcase
  end

  // input handshake
  assign b_fire    = b_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !sweep && (!b_vld_r || b_fire);
  assign accept    = in_tvalid && in_tready;
  assign in_idx    = IDX_TBL[int'(in_tdata[SID_W-1:0]) * IDX_W +: IDX_W];

  // request stage, waits for the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
      b_fwd_r <= 1'b0;
    end else begin
      if (accept) begin
        b_vld_r <= 1'b1;
        b_fwd_r <= b_fire && upd.we && (b_idx_r == in_idx);
      end else if (b_fire) begin
        b_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_op_r       <= in_tuser[0];
      b_idx_r      <= in_idx;
      b_ctr_r      <= in_tdata[SID_W +: CTR_W];
      b_fwd_data_r <= new_ent;
    end
  end

  // state store
  arw_state_mem #(
    .DEPTH  (NUM_SESSIONS),
    .ADDR_W (IDX_W),
    .ENT_W  (ENT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (accept),
    .rd_addr (in_idx),
    .rd_data (mem_rdata)
  );

  // bypass the entry written in the same cycle as the read
  assign cur = b_fwd_r ? b_fwd_data_r : mem_rdata;

  arw_window_upd #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_upd (
    .op      (b_op_r),
    .ctr     (b_ctr_r),
    .cur_hi  (cur[ENT_W-1 -: CTR_W]),
    .cur_map (cur[WINDOW_BITS-1:0]),
    .new_hi  (new_hi),
    .new_map (new_map),
    .res     (upd)
  );

  assign new_ent = {new_hi, new_map};

  // write back, or zero fill during the sweep
  assign mem_we    = sweep || (b_fire && upd.we);
  assign mem_waddr = sweep ? clr_idx_r : b_idx_r;
  assign mem_wdata = sweep ? '0 : new_ent;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (b_fire) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_acc_r     <= upd.accepted;
      out_verdict_r <= upd.verdict;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'b0000, out_verdict_r, out_acc_r};

`ifndef NO_ASSERTIONS
  // no request taken while the memory is being swept
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sweep |-> !in_tready)
    else $error("request accepted during clearing sweep");

  // a stalled request stage keeps its session
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !b_fire && !accept) |=> (b_vld_r && $stable(b_idx_r)))
    else $error("request stage lost while stalled");

  // rejected packets never touch the state
  a_reject_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (b_fire && !upd.accepted) |-> !upd.we)
    else $error("rejected packet wrote session state");

  // bypass set for a back-to-back request to the same session as the previous write
  a_fwd_same_session: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && b_fire && upd.we && (b_idx_r == in_idx)) |=> b_fwd_r)
    else $error("missing bypass for back-to-back same session");
`endif

endmodule

### rtl/arw_state_mem.sv
// arw_state_mem: per-session state store, one write and one registered read port
// depends on arw_pkg

module arw_state_mem
  import arw_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_SESSIONS,
  parameter int ADDR_W = 8,
  parameter int ENT_W  = CTR_W + DEF_WINDOW_BITS
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [ENT_W-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [ENT_W-1:0]  rd_data
);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/arw_window_upd.sv
// arw_window_upd: window compare, bitmap shift and verdict for one request
// depends on arw_pkg

module arw_window_upd
  import arw_pkg::*;
#(
  parameter int WINDOW_BITS = DEF_WINDOW_BITS
) (
  input  logic                   op,
  input  logic [CTR_W-1:0]       ctr,
  input  logic [CTR_W-1:0]       cur_hi,
  input  logic [WINDOW_BITS-1:0] cur_map,
  output logic [CTR_W-1:0]       new_hi,
  output logic [WINDOW_BITS-1:0] new_map,
  output upd_res_t               res
);

  localparam int SH_W = $clog2(WINDOW_BITS);

  logic [CTR_W:0]         diff_dn;
  logic [CTR_W-1:0]       diff_up;
  logic [CTR_W-1:0]       diff;
  logic                   ahead;
  logic                   in_win;
  logic [SH_W-1:0]        sh;
  logic [WINDOW_BITS-1:0] shifted;
  logic [WINDOW_BITS-1:0] bit_sel;

  // distance to the highest counter; borrow means the counter is ahead
  assign diff_dn = {1'b0, cur_hi} - {1'b0, ctr};
  assign diff_up = ctr - cur_hi;
  assign ahead   = diff_dn[CTR_W];
  assign diff    = ahead ? diff_up : diff_dn[CTR_W-1:0];
  assign in_win  = (diff < CTR_W'(WINDOW_BITS));
  assign sh      = diff[SH_W-1:0];
  assign shifted = cur_map << sh;
  assign bit_sel = WINDOW_BITS'(1) << sh;

  // verdict and new state
  always_comb begin
    new_hi       = cur_hi;
    new_map      = cur_map;
    res.we       = 1'b0;
    res.accepted = 1'b0;
    res.verdict  = VERDICT_TOO_OLD;
    priority if (op == OP_CLEAR) begin
      new_hi       = '0;
      new_map      = '0;
      res.we       = 1'b1;
      res.accepted = 1'b1;
      res.verdict  = VERDICT_CLEARED;
    end else if (ahead) begin
      new_hi       = ctr;
      new_map      = (in_win ? shifted : '0) | WINDOW_BITS'(1);
      res.we       = 1'b1;
      res.accepted = 1'b1;
      res.verdict  = VERDICT_NEW_HIGHEST;
    end else if (!in_win) begin
      res.verdict = VERDICT_TOO_OLD;
    end else if ((cur_map & bit_sel) != '0) begin
      res.verdict = VERDICT_REPLAY;
    end else begin
      new_map      = cur_map | bit_sel;
      res.we       = 1'b1;
      res.accepted = 1'b1;
      res.verdict  = VERDICT_FRESH;
    end
  end

endmodule

### tb/sv/testbench.sv
// testbench for anti_replay_window_check_unit: directed and random check/clear requests
// with a per-session window predictor and a scoreboard of verdicts in request order
// depends on arw_pkg and the rtl of anti_replay_window_check_unit
`timescale 1ns / 1ps

module testbench;
  import arw_pkg::*;

  localparam int WIN       = DEF_WINDOW_BITS;
  localparam int SESSIONS  = DEF_NUM_SESSIONS;
  localparam int RAND_REQS = 1700;
  localparam int IDLE_PCT  = 30;

  typedef struct {
    logic        op;
    logic [7:0]  sid;
    logic [63:0] ctr;
  } replay_req_t;

  typedef struct {
    logic [7:0] sid;
    logic       acc;
    verdict_t   verdict;
  } verdict_rec_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  // requests waiting to be driven and verdicts waiting to come out
  replay_req_t  stim_q[$];
  verdict_rec_t expected_verdicts[$];

  // predictor copy of the per-session window state
  logic [63:0] top_ctr[SESSIONS];
  logic [63:0] seen_map[SESSIONS];

  // generator view of each session, only used to shape the stimulus
  logic [63:0] gen_top[256];
  logic [63:0] last_ctr[256];

  int  mismatches;
  int  accepted_reqs;
  int  results_seen;
  int  verdict_tally[5];
  bit  req_taken;

  anti_replay_window_check_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // no idling for a stretch in the middle of the run
  function automatic bit quiet_stretch();
    return accepted_reqs >= 600 && accepted_reqs < 900;
  endfunction

  function automatic bit take_a_break();
    return !quiet_stretch() && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // window predictor: updates the session state and returns the verdict
  function automatic verdict_rec_t window_check(logic op, logic [7:0] sid, logic [63:0] ctr);
    verdict_rec_t rec;
    int           s;
    logic [63:0]  mask;
    logic [63:0]  hi;
    logic [63:0]  map;
    logic [63:0]  diff;
    logic [63:0]  bitsel;
    s      = sid % SESSIONS;
    mask   = (WIN >= 64) ? '1 : ((64'd1 << WIN) - 64'd1);
    hi     = top_ctr[s];
    map    = seen_map[s] & mask;
    rec.sid = sid;
    if (op == OP_CLEAR) begin
      top_ctr[s]  = '0;
      seen_map[s] = '0;
      rec.acc     = 1'b1;
      rec.verdict = VERDICT_CLEARED;
    end else if (ctr > hi) begin
      diff = ctr - hi;
      if (diff < WIN) begin
        map = (map << diff) & mask;
      end else begin
        map = '0;
      end
      top_ctr[s]  = ctr;
      seen_map[s] = map | 64'd1;
      rec.acc     = 1'b1;
      rec.verdict = VERDICT_NEW_HIGHEST;
    end else begin
      diff = hi - ctr;
      if (diff >= WIN) begin
        rec.acc     = 1'b0;
        rec.verdict = VERDICT_TOO_OLD;
      end else begin
        bitsel = 64'd1 << diff;
        if ((map & bitsel) != 0) begin
          rec.acc     = 1'b0;
          rec.verdict = VERDICT_REPLAY;
        end else begin
          seen_map[s] = map | bitsel;
          rec.acc     = 1'b1;
          rec.verdict = VERDICT_FRESH;
        end
      end
    end
    return rec;
  endfunction

  task automatic add_req(logic op, logic [7:0] sid, logic [63:0] ctr);
    replay_req_t r;
    r.op  = op;
    r.sid = sid;
    r.ctr = ctr;
    stim_q.push_back(r);
  endtask

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin : req_driver
    replay_req_t nxt;
    if (rst_n && (!in_tvalid || req_taken)) begin
      req_taken = 1'b0;
      if (stim_q.size() != 0 && !take_a_break()) begin
        nxt = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {nxt.ctr, nxt.sid};
        in_tuser  <= nxt.op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (rst_n) begin
      out_tready <= !take_a_break();
    end
  end

  // accepted request: predict its verdict
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      expected_verdicts.push_back(window_check(in_tuser[0], in_tdata[7:0], in_tdata[71:8]));
      accepted_reqs++;
      req_taken = 1'b1;
    end
  end

  // accepted result: compare with the oldest prediction
  always @(posedge clk) begin : verdict_monitor
    verdict_rec_t exp_rec;
    logic         got_acc;
    logic [2:0]   got_verdict;
    if (rst_n && out_tvalid && out_tready) begin
      got_acc     = out_tdata[0];
      got_verdict = out_tdata[3:1];
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: result with no request pending, expected none, got acc %0b verdict %0d",
                 $time, got_acc, got_verdict);
        mismatches++;
      end else begin
        exp_rec = expected_verdicts.pop_front();
        if (exp_rec.verdict <= VERDICT_CLEARED) verdict_tally[exp_rec.verdict]++;
        if (got_acc !== exp_rec.acc) begin
          $display("%0t: session %0d accepted mismatch, expected %0b, got %0b",
                   $time, exp_rec.sid, exp_rec.acc, got_acc);
          mismatches++;
        end
        if (got_verdict !== exp_rec.verdict) begin
          $display("%0t: session %0d verdict mismatch, expected %0d (%s), got %0d",
                   $time, exp_rec.sid, exp_rec.verdict, exp_rec.verdict.name(), got_verdict);
          mismatches++;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : main_seq
    int          k;
    int          r;
    int          sid;
    int          prev_sid;
    logic [63:0] c;
    logic [63:0] all_ones;

    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    req_taken  = 1'b0;
    mismatches    = 0;
    accepted_reqs = 0;
    results_seen  = 0;
    all_ones      = '1;
    foreach (verdict_tally[i]) verdict_tally[i] = 0;
    foreach (top_ctr[i]) begin
      top_ctr[i]  = '0;
      seen_map[i] = '0;
    end
    foreach (gen_top[i]) begin
      gen_top[i]  = '0;
      last_ctr[i] = '0;
    end

    // fresh session takes counter zero, then sees it as a replay
    add_req(OP_CHECK, 8'd0, 64'd0);
    add_req(OP_CHECK, 8'd0, 64'd0);
    add_req(OP_CHECK, 8'd0, 64'd5);
    add_req(OP_CHECK, 8'd0, 64'd3);
    add_req(OP_CHECK, 8'd0, 64'd3);
    // gap past the window empties the map; window edges on both sides
    add_req(OP_CHECK, 8'd0, 64'd100);
    add_req(OP_CHECK, 8'd0, 64'd36);
    add_req(OP_CHECK, 8'd0, 64'd37);
    add_req(OP_CHECK, 8'd0, 64'd163);
    add_req(OP_CHECK, 8'd0, 64'd100);
    add_req(OP_CHECK, 8'd0, 64'd227);
    add_req(OP_CHECK, 8'd0, 64'd163);
    // top of the counter range on the last session
    add_req(OP_CHECK, 8'd255, all_ones);
    add_req(OP_CHECK, 8'd255, 64'd0);
    add_req(OP_CHECK, 8'd255, all_ones);
    add_req(OP_CHECK, 8'd255, all_ones - 64'd63);
    add_req(OP_CHECK, 8'd255, all_ones - 64'd64);
    // clear ignores the counter and restarts the session
    add_req(OP_CLEAR, 8'd255, all_ones);
    add_req(OP_CHECK, 8'd255, 64'd0);
    add_req(OP_CLEAR, 8'd0, 64'd0);
    add_req(OP_CHECK, 8'd0, 64'd1);
    add_req(OP_CHECK, 8'hAA, 64'h5555_5555_5555_5555);
    add_req(OP_CHECK, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA);
    add_req(OP_CHECK, 8'h55, 64'hAAAA_AAAA_AAAA_AAAB);

    // random part: mostly walks along each session's window, some noise
    prev_sid = 0;
    for (k = 0; k < RAND_REQS; k++) begin
      r = $urandom_range(99);
      if (r < 20) begin
        sid = prev_sid;
      end else if (r < 60) begin
        sid = $urandom_range(3) * 64 + 5;
      end else begin
        sid = $urandom_range(255);
      end
      r = $urandom_range(99);
      if (r < 3) begin
        add_req(OP_CLEAR, sid[7:0], {$urandom, $urandom});
        gen_top[sid] = '0;
      end else begin
        if (r < 38) begin
          c = gen_top[sid] + $urandom_range(1, 3);
        end else if (r < 48) begin
          c = gen_top[sid] + $urandom_range(4, 80);
        end else if (r < 78) begin
          c = gen_top[sid] - $urandom_range(0, 63);
        end else if (r < 86) begin
          c = gen_top[sid] - $urandom_range(64, 70);
        end else if (r < 93) begin
          c = {$urandom, $urandom};
        end else begin
          c = last_ctr[sid];
        end
        if (c > gen_top[sid]) gen_top[sid] = c;
        last_ctr[sid] = c;
        add_req(OP_CHECK, sid[7:0], c);
      end
      prev_sid = sid;
    end

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // drain, then let the pipeline settle
    @(posedge clk);
    while (stim_q.size() != 0 || in_tvalid || expected_verdicts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run covered %0d requests and %0d results", accepted_reqs, results_seen);
    $display("verdicts: new highest %0d, fresh %0d, too old %0d, replay %0d, cleared %0d",
             verdict_tally[VERDICT_NEW_HIGHEST], verdict_tally[VERDICT_FRESH],
             verdict_tally[VERDICT_TOO_OLD], verdict_tally[VERDICT_REPLAY],
             verdict_tally[VERDICT_CLEARED]);
    if (mismatches == 0) begin
      $display("PASS anti_replay_window_check_unit");
    end else begin
      $display("FAIL anti_replay_window_check_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAIL anti_replay_window_check_unit");
    $finish;
  end

endmodule
